// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions on aclk, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while aresetn is high
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked at every edge, reset included
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/ltarb_pkg.sv
// ----------------------------------------------------------------------------
// ltarb_pkg
// types, codes and constants shared by the lottery ticket arbiter modules
// ----------------------------------------------------------------------------
package ltarb_pkg;

    localparam int LTARB_QUEUE_DEPTH = 16;
    localparam int LTARB_TICKET_MAX  = 255;

    localparam int ID_W     = 8;
    localparam int TICKET_W = 8;
    localparam int RAND_W   = 31;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 2'd0,
        OP_DRAW      = 2'd1,
        OP_SET_READY = 2'd2
    } op_e_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NO_TICKETS = 2'd2,
        STAT_NOT_FOUND  = 2'd3
    } status_e_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SUM,
        S_CHECK,
        S_DIV,
        S_FIND,
        S_SHIFT,
        S_SRCH,
        S_RESP
    } fsm_state_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     requester_id;
        logic [TICKET_W-1:0] ticket_count;
        logic                ready_flag;
        logic [RAND_W-1:0]   random_value;
    } in_item_t;

    typedef struct packed {
        logic                winner_valid;
        logic [ID_W-1:0]     winner_id;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TICKET_W-1:0] tickets;
        logic                ready;
    } entry_t;

    typedef struct packed {
        logic      req_load;
        logic      add_wr;
        logic      walk_init;
        logic      walk;
        logic      shift_init;
        logic      shift_wr;
        logic      srch_wr;
        logic      pop;
        logic      div_start;
        logic      res_load;
        logic      res_win;
        status_e_t res_code;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            last_proc;
        logic            sum_zero;
        logic            div_done;
        logic            find_hit;
        logic            srch_hit;
        logic            shift_done;
    } dp_stat_t;

endpackage

// File: rtl/ltarb_mod.sv
// ----------------------------------------------------------------------------
// ltarb_mod
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module ltarb_mod #(
    parameter int DIVISOR_W = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ltarb_pkg::RAND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         done,
    output logic [DIVISOR_W-1:0]         rem
);
    import ltarb_pkg::*;

    localparam int STEP_W = $clog2(RAND_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [RAND_W-1:0]    dvd_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic [DIVISOR_W-1:0] rem_next;

    always_comb begin
        shifted  = {rem_reg, dvd_reg[RAND_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = (shifted >= {1'b0, dsr_reg}) ? diff[DIVISOR_W-1:0]
                                                : shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(RAND_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/ltarb_dp.sv
// ----------------------------------------------------------------------------
// ltarb_dp
// queue memory, walk pointer, ticket accumulator, remainder unit and
// result registers
// ----------------------------------------------------------------------------
module ltarb_dp #(
    parameter int QUEUE_DEPTH = ltarb_pkg::LTARB_QUEUE_DEPTH,
    parameter int TICKET_MAX  = ltarb_pkg::LTARB_TICKET_MAX
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ltarb_pkg::in_item_t  s_data,
    input  ltarb_pkg::ctrl_cmd_t cmd,
    output ltarb_pkg::dp_stat_t  stat,
    output ltarb_pkg::out_item_t m_data
);
    import ltarb_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int SUM_W = $clog2(QUEUE_DEPTH * ((1 << TICKET_W) - 1) + 1);

    entry_t mem [QUEUE_DEPTH];

    in_item_t   req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] tgt_reg;
    out_item_t        res_reg;
    out_item_t        out_reg;

    logic             issue;
    logic [SUM_W-1:0] run;
    logic [SUM_W-1:0] rem;
    logic             div_done;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [TICKET_W-1:0] tickets_sat;

    ltarb_mod #(
        .DIVISOR_W (SUM_W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (req_reg.random_value),
        .divisor  (acc_reg),
        .done     (div_done),
        .rem      (rem)
    );

    always_comb begin
        issue = cmd.walk && (idx_reg < count_reg);
        run   = acc_reg + (rd_data_reg.ready ? SUM_W'(rd_data_reg.tickets) : SUM_W'(0));
        tickets_sat = ({9'd0, req_reg.ticket_count} > 17'(TICKET_MAX))
                    ? TICKET_W'(TICKET_MAX) : req_reg.ticket_count;

        stat.op         = req_reg.op;
        stat.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty      = (count_reg == '0);
        stat.last_proc  = rd_vld_reg && (CNT_W'(rd_idx_reg) == count_reg - CNT_W'(1));
        stat.sum_zero   = (acc_reg == '0);
        stat.div_done   = div_done;
        stat.find_hit   = rd_vld_reg && rd_data_reg.ready && (run >= tgt_reg);
        stat.srch_hit   = rd_vld_reg && (rd_data_reg.id == req_reg.requester_id);
        stat.shift_done = (idx_reg >= count_reg) && !rd_vld_reg;

        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = rd_data_reg;
        if (cmd.add_wr) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = '{id: req_reg.requester_id, tickets: tickets_sat,
                        ready: req_reg.ready_flag};
        end else if (cmd.shift_wr && rd_vld_reg) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg - IDX_W'(1);
        end else if (cmd.srch_wr) begin
            wr_en         = 1'b1;
            wr_data.ready = req_reg.ready_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.walk_init) begin
                idx_reg    <= '0;
                rd_vld_reg <= 1'b0;
            end else if (cmd.shift_init) begin
                idx_reg    <= CNT_W'(rd_idx_reg) + CNT_W'(1);
                rd_vld_reg <= 1'b0;
            end else begin
                if (issue) begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                rd_vld_reg <= issue;
            end
            if (cmd.add_wr) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.pop) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_reg <= s_data;
        end
        if (cmd.walk_init) begin
            acc_reg <= '0;
            tgt_reg <= rem + SUM_W'(1);
        end else if (cmd.walk && rd_vld_reg) begin
            acc_reg <= run;
        end
        if (cmd.res_load) begin
            res_reg.winner_valid <= cmd.res_win;
            res_reg.winner_id    <= cmd.res_win ? rd_data_reg.id : ID_W'(0);
            res_reg.status       <= cmd.res_code;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_data = out_reg;

endmodule

// File: rtl/ltarb_ctrl.sv
// ----------------------------------------------------------------------------
// ltarb_ctrl
// sequencer for add, draw and set-ready, plus the handshakes
// ----------------------------------------------------------------------------
module ltarb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ltarb_pkg::dp_stat_t  stat,
    output ltarb_pkg::ctrl_cmd_t cmd
);
    import ltarb_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = STAT_OK;
        unique case (state_reg)
            S_IDLE: begin
                cmd.req_load = s_valid;
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.res_load = 1'b1;
                state_next   = S_RESP;
                unique case (stat.op)
                    OP_ADD: begin
                        if (stat.full) begin
                            cmd.res_code = STAT_FULL;
                        end else begin
                            cmd.add_wr = 1'b1;
                        end
                    end
                    OP_DRAW: begin
                        if (stat.empty) begin
                            cmd.res_code = STAT_NO_TICKETS;
                        end else begin
                            cmd.res_load  = 1'b0;
                            cmd.walk_init = 1'b1;
                            state_next    = S_SUM;
                        end
                    end
                    OP_SET_READY: begin
                        if (stat.empty) begin
                            cmd.res_code = STAT_NOT_FOUND;
                        end else begin
                            cmd.res_load  = 1'b0;
                            cmd.walk_init = 1'b1;
                            state_next    = S_SRCH;
                        end
                    end
                    default: begin
                        cmd.res_code = STAT_OK;
                    end
                endcase
            end
            S_SUM: begin
                cmd.walk = 1'b1;
                if (stat.last_proc) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.sum_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = STAT_NO_TICKETS;
                    state_next   = S_RESP;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_FIND;
                end
            end
            S_FIND: begin
                cmd.walk = 1'b1;
                if (stat.find_hit) begin
                    cmd.shift_init = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_win    = 1'b1;
                    state_next     = S_SHIFT;
                end else if (stat.last_proc) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = STAT_NO_TICKETS;
                    state_next   = S_RESP;
                end
            end
            S_SHIFT: begin
                cmd.walk     = 1'b1;
                cmd.shift_wr = 1'b1;
                if (stat.shift_done) begin
                    cmd.pop    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_SRCH: begin
                cmd.walk = 1'b1;
                if (stat.srch_hit) begin
                    cmd.srch_wr  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = S_RESP;
                end else if (stat.last_proc) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = STAT_NOT_FOUND;
                    state_next   = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: rtl/lottery_ticket_arbiter.sv
// ----------------------------------------------------------------------------
// lottery_ticket_arbiter
// ordered requester queue with ticket-weighted draw and removal of the winner
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | ltarb_pkg::in_item_t
//  m_      | out       | m_valid / m_ready  | ltarb_pkg::out_item_t
//
//  one transaction at a time; set-ready walks the queue for the id, draw
//  sums ready tickets in one walk over the single queue read port, runs a
//  bit-serial remainder step, then finds the winner and shifts the tail down
//  in two more walks; aresetn empties the queue at once, no clearing pass
//  a finished result waits in the output register while the next
//  transaction is taken; a new result waits for that register to drain
// ----------------------------------------------------------------------------
module lottery_ticket_arbiter #(
    parameter int QUEUE_DEPTH = ltarb_pkg::LTARB_QUEUE_DEPTH,
    parameter int TICKET_MAX  = ltarb_pkg::LTARB_TICKET_MAX
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ltarb_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ltarb_pkg::out_item_t m_data
);
    import ltarb_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ltarb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ltarb_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICKET_MAX  (TICKET_MAX)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// File: rtl/ltarb_checker.sv
// ----------------------------------------------------------------------------
// ltarb_checker
// port-level checks on the lottery ticket arbiter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ltarb_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input ltarb_pkg::out_item_t m_data
);
    import ltarb_pkg::*;

    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "held result")
    `ASSERT_RST(a_rst_idle, !aresetn |=> !m_valid, "result valid after reset")
    `ASSERT_CLK(a_win_ok, m_valid && m_data.winner_valid |-> m_data.status == STAT_OK, "win status")
    `ASSERT_CLK(a_id_zero, m_valid && !m_data.winner_valid |-> m_data.winner_id == '0, "stray id")
    `ASSERT_CLK(a_busy_before, $rose(m_valid) |-> $past(!s_ready), "result while idle")

endmodule

bind lottery_ticket_arbiter ltarb_checker u_ltarb_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for lottery_ticket_arbiter: a queued driver feeds
// add, draw, set-ready and unused-opcode transactions; a scoreboard mirrors
// the requester queue and checks every result in order under random stalls on
// both sides, then with none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ltarb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t    pending_requests[$];
    out_item_t   pending_outcomes[$];
    entry_t      shadow_queue[LTARB_QUEUE_DEPTH];
    int unsigned queued_entries = 0;
    int          send_idle_pct  = 25;
    int          recv_idle_pct  = 55;
    int          failures       = 0;

    lottery_ticket_arbiter DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic out_item_t arbitrate(in_item_t req);
        out_item_t   res;
        int unsigned total;
        int unsigned goal;
        int unsigned running;
        int unsigned slot;
        bit          hit;
        res        = '0;
        res.status = STAT_OK;
        total      = 0;
        running    = 0;
        hit        = 1'b0;
        case (req.op)
            OP_ADD: begin
                if (queued_entries >= LTARB_QUEUE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    shadow_queue[queued_entries].id      = req.requester_id;
                    shadow_queue[queued_entries].tickets =
                        (req.ticket_count > LTARB_TICKET_MAX) ?
                        TICKET_W'(LTARB_TICKET_MAX) : req.ticket_count;
                    shadow_queue[queued_entries].ready   = req.ready_flag;
                    queued_entries++;
                end
            end
            OP_DRAW: begin
                for (int i = 0; i < queued_entries; i++) begin
                    if (shadow_queue[i].ready) begin
                        total += shadow_queue[i].tickets;
                    end
                end
                if (total == 0) begin
                    res.status = STAT_NO_TICKETS;
                end else begin
                    goal = req.random_value % total + 1;
                    for (int i = 0; i < queued_entries && !hit; i++) begin
                        if (shadow_queue[i].ready) begin
                            running += shadow_queue[i].tickets;
                            if (running >= goal) begin
                                hit  = 1'b1;
                                slot = i;
                            end
                        end
                    end
                    if (hit) begin
                        res.winner_valid = 1'b1;
                        res.winner_id    = shadow_queue[slot].id;
                        for (int i = slot; i + 1 < queued_entries; i++) begin
                            shadow_queue[i] = shadow_queue[i + 1];
                        end
                        queued_entries--;
                    end
                end
            end
            OP_SET_READY: begin
                res.status = STAT_NOT_FOUND;
                for (int i = 0; i < queued_entries && !hit; i++) begin
                    if (shadow_queue[i].id == req.requester_id) begin
                        shadow_queue[i].ready = req.ready_flag;
                        res.status            = STAT_OK;
                        hit                   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_outcomes.push_back(arbitrate(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_requests.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_data);
                    failures++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_data.winner_valid !== want.winner_valid) begin
                        $display("%0t: winner_valid mismatch, expected %0d, actual %0d",
                                 $time, want.winner_valid, m_data.winner_valid);
                        failures++;
                    end
                    if (m_data.winner_id !== want.winner_id) begin
                        $display("%0t: winner_id mismatch, expected %0d, actual %0d",
                                 $time, want.winner_id, m_data.winner_id);
                        failures++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_data.status);
                        failures++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_request(logic [OP_W-1:0] op, int id, int tickets, int ready,
                                int unsigned rnd);
        in_item_t req;
        req.op           = op;
        req.requester_id = ID_W'(id);
        req.ticket_count = TICKET_W'(tickets);
        req.ready_flag   = ready[0];
        req.random_value = RAND_W'(rnd);
        pending_requests.push_back(req);
    endtask

    task automatic queue_random_requests(int count);
        int               roll;
        bit               filling;
        logic [OP_W-1:0]  op;
        int               id;
        int unsigned      rnd;
        for (int k = 0; k < count; k++) begin
            filling = ((k / 40) % 2) == 0;
            roll    = $urandom_range(99);
            if (roll < 5) begin
                op = OP_UNUSED;
            end else if (roll < (filling ? 62 : 30)) begin
                op = OP_ADD;
            end else if (roll < (filling ? 82 : 78)) begin
                op = OP_DRAW;
            end else begin
                op = OP_SET_READY;
            end
            id  = ($urandom_range(99) < 80) ? $urandom_range(23) : $urandom_range(255);
            rnd = ($urandom_range(99) < 80) ? ($urandom() & 32'h7fff_ffff) :
                  $urandom_range(600);
            push_request(op, id, $urandom_range(255), $urandom_range(99) < 75, rnd);
        end
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() > 0 || s_valid || pending_outcomes.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue corner cases
        push_request(OP_DRAW, 0, 0, 0, 5);
        push_request(OP_SET_READY, 5, 0, 1, 0);
        push_request(OP_UNUSED, 255, 255, 1, 32'h7fff_ffff);
        // zero tickets and not-ready entries never win; set-ready then lets one win
        push_request(OP_ADD, 0, 0, 1, 0);
        push_request(OP_DRAW, 0, 0, 0, 17);
        push_request(OP_ADD, 255, 255, 0, 0);
        push_request(OP_DRAW, 0, 0, 0, 17);
        push_request(OP_SET_READY, 255, 0, 1, 0);
        push_request(OP_DRAW, 0, 0, 0, 32'h7fff_ffff);
        // fill to capacity with a duplicate id, overflow, then set-ready and draw
        push_request(OP_ADD, 7, 40, 1, 0);
        push_request(OP_ADD, 7, 90, 1, 0);
        for (int k = 0; k < 13; k++) begin
            push_request(OP_ADD, k + 1, (k * 37) % 256, k % 3 != 0, 0);
        end
        push_request(OP_ADD, 200, 255, 1, 0);
        push_request(OP_SET_READY, 7, 0, 0, 0);
        push_request(OP_SET_READY, 99, 0, 1, 0);
        push_request(OP_DRAW, 0, 0, 0, 0);
        queue_random_requests(420);
        wait_for_drain();

        send_idle_pct = 55;
        recv_idle_pct = 25;
        queue_random_requests(450);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_requests(450);
        wait_for_drain();

        repeat (200) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: lottery_ticket_arbiter.f
+incdir+rtl
rtl/ltarb_pkg.sv
rtl/ltarb_mod.sv
rtl/ltarb_dp.sv
rtl/ltarb_ctrl.sv
rtl/lottery_ticket_arbiter.sv
rtl/ltarb_checker.sv
tb/tb.sv
